### src/stack_handle_allocator_assert.svh
// Assertion macros for the stack handle allocator.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef STACK_HANDLE_ALLOCATOR_ASSERT_SVH
`define STACK_HANDLE_ALLOCATOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SHA_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define SHA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SHA_ASSERT_NOW(name, ante, cons, msg)
`define SHA_ASSERT_NEXT(name, ante, cons, msg)
`endif
`endif

### src/sha_pkg.sv
package sha_pkg;

  // Fixed field widths of the item and result ports
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned HANDLE_W   = 10;
  localparam int unsigned SIZE_W     = 20;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned POOL_CFG_W = 21;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_POOL     = 3'd1,
    STAT_TABLE    = 3'd2,
    STAT_NOHANDLE = 3'd3,
    STAT_FREED    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_LOOKUP,
    S_POP_RD,
    S_POP_CHK,
    S_RESP
  } sha_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    latch_in;
    logic    clear_res;
    logic    alloc_exec;
    logic    rd_handle;
    logic    rd_top;
    logic    mark_freed;
    logic    pop;
    logic    cap_capture;
    logic    set_status;
    status_e status;
  } sha_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    action_e action;
    logic    handle_ok;
    logic    rd_freed;
    logic    count_zero;
  } sha_stat_t;

endpackage

### src/sha_ctrl.sv
module sha_ctrl import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sha_stat_t stat_i,
  output sha_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  sha_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (stat_i.action)
          ACT_ALLOC: state_d = S_ALLOC;
          ACT_FREE, ACT_QUERY: state_d = stat_i.handle_ok ? S_LOOKUP : S_RESP;
          default: state_d = S_RESP;
        endcase
      end
      S_ALLOC: state_d = S_RESP;
      S_LOOKUP: begin
        if (stat_i.rd_freed || stat_i.action == ACT_QUERY) state_d = S_RESP;
        else state_d = S_POP_RD;
      end
      S_POP_RD: state_d = stat_i.count_zero ? S_RESP : S_POP_CHK;
      S_POP_CHK: state_d = stat_i.rd_freed ? S_POP_RD : S_RESP;
      S_RESP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.status = STAT_OK;
    busy_o = (state_q != S_IDLE);
    done_o = (state_q == S_RESP);
    case (state_q)
      S_IDLE: cmd_o.latch_in = start_i;
      S_DECODE: begin
        cmd_o.clear_res = 1'b1;
        if (stat_i.action == ACT_FREE || stat_i.action == ACT_QUERY) begin
          if (stat_i.handle_ok) begin
            cmd_o.rd_handle = 1'b1;
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = STAT_NOHANDLE;
          end
        end
      end
      S_ALLOC: cmd_o.alloc_exec = 1'b1;
      S_LOOKUP: begin
        if (stat_i.rd_freed) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = STAT_FREED;
        end else if (stat_i.action == ACT_QUERY) begin
          cmd_o.cap_capture = 1'b1;
        end else begin
          cmd_o.mark_freed = 1'b1;
        end
      end
      S_POP_RD: cmd_o.rd_top = !stat_i.count_zero;
      S_POP_CHK: cmd_o.pop = stat_i.rd_freed;
      default: ;
    endcase
  end

endmodule

### src/sha_dp.sv
module sha_dp import sha_pkg::*; #(
  parameter int unsigned TABLE_DEPTH    = 1024,
  parameter int unsigned POOL_ADDR_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [POOL_CFG_W-1:0] cfg_data_i,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [HANDLE_W-1:0]   handle_i,
  input  logic [SIZE_W-1:0]     size_i,
  input  sha_cmd_t              cmd_i,
  output sha_stat_t             stat_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [HANDLE_W-1:0]   handle_out_o,
  output logic [SIZE_W-1:0]     start_offset_o,
  output logic [SIZE_W-1:0]     capacity_o,
  output logic [HANDLE_W-1:0]   entries_used_o
);

  localparam int unsigned CW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;
  localparam int unsigned PW   = POOL_ADDR_BITS;
  localparam int unsigned DW   = (PW > SIZE_W) ? PW : SIZE_W;
  localparam int unsigned SW   = DW + 1;
  localparam int unsigned LW   = (PW + 1 > POOL_CFG_W) ? PW + 1 : POOL_CFG_W;
  localparam int unsigned KW   = (SW > LW) ? SW : LW;
  localparam int unsigned MW   = SIZE_W + 1;
  localparam logic [LW-1:0] POOL_SPAN = LW'(1) << PW;
  localparam logic [CW-1:0] TOP_IDX   = CW'(TABLE_DEPTH - 1);

  logic [POOL_CFG_W-1:0] pool_q;
  logic [CW-1:0]         count_q, count_d;
  logic [PW-1:0]         fill_q, fill_d;
  action_e               action_q;
  logic [HANDLE_W-1:0]   handle_q;
  logic [SIZE_W-1:0]     size_q;

  // Entry table: freed flag over capacity
  logic [MW-1:0] mem [TABLE_DEPTH];
  logic [MW-1:0] rd_q;
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata;

  status_e             status_q, status_d;
  logic [HANDLE_W-1:0] hout_q, hout_d;
  logic [SIZE_W-1:0]   start_q, start_d;
  logic [SIZE_W-1:0]   cap_q, cap_d;

  logic [CMPW-1:0]   count_ext, handle_ext;
  logic [CW-1:0]     handle_addr, top_addr;
  logic [LW-1:0]     pool_lim;
  logic [SW-1:0]     sum;
  logic [DW-1:0]     fill_ext, diff;
  logic              pool_fail, table_fail, alloc_ok;
  logic              rd_freed;
  logic [SIZE_W-1:0] rd_cap;

  // Index and bound arithmetic
  always_comb begin
    count_ext   = CMPW'(count_q);
    handle_ext  = CMPW'(handle_q);
    handle_addr = handle_ext[CW-1:0];
    top_addr    = count_q - CW'(1);
    pool_lim    = (LW'(pool_q) > POOL_SPAN) ? POOL_SPAN : LW'(pool_q);
    sum         = SW'(fill_q) + SW'(size_q);
    pool_fail   = KW'(sum) >= KW'(pool_lim);
    table_fail  = (count_q == TOP_IDX);
    alloc_ok    = cmd_i.alloc_exec && !pool_fail && !table_fail;
    rd_freed    = rd_q[SIZE_W];
    rd_cap      = rd_q[SIZE_W-1:0];
    fill_ext    = DW'(fill_q);
    diff        = fill_ext - DW'(rd_cap);
  end

  // Table port selection
  always_comb begin
    mem_we    = alloc_ok || cmd_i.mark_freed;
    mem_waddr = alloc_ok ? count_q : handle_addr;
    mem_wdata = alloc_ok ? {1'b0, size_q} : {1'b1, rd_cap};
    mem_re    = cmd_i.rd_handle || cmd_i.rd_top;
    mem_raddr = cmd_i.rd_top ? top_addr : handle_addr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  // Stack pointers: push on a good allocate, drop one entry per pop
  always_comb begin
    count_d = count_q;
    fill_d  = fill_q;
    if (alloc_ok) begin
      count_d = count_q + CW'(1);
      fill_d  = sum[PW-1:0];
    end else if (cmd_i.pop) begin
      count_d = top_addr;
      fill_d  = diff[PW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= '0;
      count_q <= '0;
      fill_q  <= '0;
    end else begin
      if (cfg_we_i) pool_q <= cfg_data_i;
      count_q <= count_d;
      fill_q  <= fill_d;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      action_q <= action_e'(action_i);
      handle_q <= handle_i;
      size_q   <= size_i;
    end
  end

  // Build the result
  always_comb begin
    status_d = status_q;
    hout_d   = hout_q;
    start_d  = start_q;
    cap_d    = cap_q;
    if (cmd_i.clear_res) begin
      status_d = STAT_OK;
      hout_d   = '0;
      start_d  = '0;
      cap_d    = '0;
    end
    if (cmd_i.set_status) status_d = cmd_i.status;
    if (cmd_i.alloc_exec) begin
      if (pool_fail) begin
        status_d = STAT_POOL;
      end else if (table_fail) begin
        status_d = STAT_TABLE;
      end else begin
        hout_d  = count_ext[HANDLE_W-1:0];
        start_d = fill_ext[SIZE_W-1:0];
      end
    end
    if (cmd_i.cap_capture) cap_d = rd_cap;
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hout_q   <= hout_d;
    start_q  <= start_d;
    cap_q    <= cap_d;
  end

  assign stat_o.action     = action_q;
  assign stat_o.handle_ok  = handle_ext < count_ext;
  assign stat_o.rd_freed   = rd_freed;
  assign stat_o.count_zero = (count_q == '0);

  assign status_o       = status_q;
  assign handle_out_o   = hout_q;
  assign start_offset_o = start_q;
  assign capacity_o     = cap_q;
  assign entries_used_o = count_ext[HANDLE_W-1:0];

endmodule

### src/stack_handle_allocator.sv
// Stack allocator over a byte pool with a table of handles.
// Items: raise start with action_i, handle_i and size_i; the item is taken
// at a clock edge where start is high and busy is low. busy stays high until
// the result has been shown. The result is on the result ports for one cycle
// with done_o high; the receiver cannot stall it, so it must take it then.
// Allocate, query of a known handle and a free of an already freed entry:
// decode, then the allocate or the table lookup, then the result.
// Action 3 and a free or query of an unknown handle skip the table read:
// decode, then the result.
// A free that succeeds walks down the table, one registered table read per
// step: after the lookup it reads the top entry and pops it while it is
// marked freed, and stops on a live entry or when it empties the table.
// The entry table has a single read port.
// Configuration: pool_size is written through cfg_valid_i/cfg_data_i, always
// ready; write it only while busy is low.
// Reset clears the pool size, the entry count, the fill offset and the
// controller; the entry table needs no clearing, as only entries below the
// count are ever read.
module stack_handle_allocator import sha_pkg::*; #(
  parameter int unsigned TABLE_DEPTH    = 1024,
  parameter int unsigned POOL_ADDR_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [ACTION_W-1:0]   action_i,
  input  logic [HANDLE_W-1:0]   handle_i,
  input  logic [SIZE_W-1:0]     size_i,
  output logic                  done_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [HANDLE_W-1:0]   handle_out_o,
  output logic [SIZE_W-1:0]     start_offset_o,
  output logic [SIZE_W-1:0]     capacity_o,
  output logic [HANDLE_W-1:0]   entries_used_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [POOL_CFG_W-1:0] cfg_data_i
);

  `include "stack_handle_allocator_assert.svh"

  sha_cmd_t  dp_cmd;
  sha_stat_t dp_stat;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  sha_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  sha_dp #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .POOL_ADDR_BITS (POOL_ADDR_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .handle_i       (handle_i),
    .size_i         (size_i),
    .cmd_i          (dp_cmd),
    .stat_o         (dp_stat),
    .status_o       (status_o),
    .handle_out_o   (handle_out_o),
    .start_offset_o (start_offset_o),
    .capacity_o     (capacity_o),
    .entries_used_o (entries_used_o)
  );

  `SHA_ASSERT_NOW(a_done_in_busy, done_o, busy, "result strobe outside a busy period")
  `SHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `SHA_ASSERT_NEXT(a_done_idle, done_o, !busy, "block stayed busy after its result")
  `SHA_ASSERT_NOW(a_alloc_count, done_o && dp_stat.action == ACT_ALLOC && status_o == STAT_OK, entries_used_o == handle_out_o + HANDLE_W'(1), "allocate result disagrees with entry count")

endmodule

### verif/tb.sv
module tb;
  import sha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS     = 1024;
  localparam int unsigned POOL_BITS = 20;
  localparam longint unsigned POOL_SPAN = 64'd1 << POOL_BITS;
  localparam longint unsigned POOL_MASK = POOL_SPAN - 1;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [POOL_CFG_W-1:0] POOL_REG_MAX = '1;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SIZE_W-1:0]   start_offset;
    logic [SIZE_W-1:0]   capacity;
    logic [HANDLE_W-1:0] entries_used;
  } alloc_result_t;

  typedef enum bit {ROW_CFG, ROW_OP} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [POOL_CFG_W-1:0] pool;
    logic [ACTION_W-1:0]   act;
    logic [HANDLE_W-1:0]   hnd;
    logic [SIZE_W-1:0]     sz;
    bit                    typed;
    alloc_result_t         want;
  } plan_row_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start          = 1'b0;
  logic                  busy;
  logic [ACTION_W-1:0]   action_i       = '0;
  logic [HANDLE_W-1:0]   handle_i       = '0;
  logic [SIZE_W-1:0]     size_i         = '0;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [HANDLE_W-1:0]   handle_out_o;
  logic [SIZE_W-1:0]     start_offset_o;
  logic [SIZE_W-1:0]     capacity_o;
  logic [HANDLE_W-1:0]   entries_used_o;
  logic                  cfg_valid_i    = 1'b0;
  logic                  cfg_ready_o;
  logic [POOL_CFG_W-1:0] cfg_data_i     = '0;

  // Allocator state as the testbench tracks it
  longint unsigned       pool_bytes = 0;
  longint unsigned       pool_top   = 0;
  int unsigned           live_slots = 0;
  logic [SIZE_W-1:0]     slot_len      [SLOTS];
  bit                    slot_released [SLOTS];

  alloc_result_t         pending_results[$];
  plan_row_t             directed_plan[$];
  int unsigned           mismatches = 0;
  bit                    gaps_on    = 1'b1;

  stack_handle_allocator #(
    .TABLE_DEPTH   (SLOTS),
    .POOL_ADDR_BITS(POOL_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .handle_i      (handle_i),
    .size_i        (size_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .handle_out_o  (handle_out_o),
    .start_offset_o(start_offset_o),
    .capacity_o    (capacity_o),
    .entries_used_o(entries_used_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Clamp the pool register to the addressable span
  function automatic longint unsigned pool_limit();
    return (pool_bytes > POOL_SPAN) ? POOL_SPAN : pool_bytes;
  endfunction

  // Apply one item to the tracked state and return the result it gives
  function automatic alloc_result_t apply_request(logic [ACTION_W-1:0] act,
                                                  logic [HANDLE_W-1:0] hnd,
                                                  logic [SIZE_W-1:0] sz);
    alloc_result_t r;
    r = '0;
    r.status = STAT_OK;
    case (act)
      ACT_ALLOC: begin
        if (pool_top + sz >= pool_limit()) begin
          r.status = STAT_POOL;
        end else if (live_slots + 1 >= SLOTS) begin
          r.status = STAT_TABLE;
        end else begin
          slot_len[live_slots]      = sz;
          slot_released[live_slots] = 1'b0;
          r.handle_out   = live_slots[HANDLE_W-1:0];
          r.start_offset = pool_top[SIZE_W-1:0];
          pool_top       = (pool_top + sz) & POOL_MASK;
          live_slots++;
        end
      end
      ACT_FREE: begin
        if (hnd >= live_slots) begin
          r.status = STAT_NOHANDLE;
        end else if (slot_released[hnd]) begin
          r.status = STAT_FREED;
        end else begin
          slot_released[hnd] = 1'b1;
          // pop released entries off the top, returning their bytes
          while (live_slots > 0 && slot_released[live_slots-1]) begin
            live_slots--;
            pool_top = (pool_top - slot_len[live_slots]) & POOL_MASK;
            slot_released[live_slots] = 1'b0;
          end
        end
      end
      ACT_QUERY: begin
        if (hnd >= live_slots) r.status = STAT_NOHANDLE;
        else if (slot_released[hnd]) r.status = STAT_FREED;
        else r.capacity = slot_len[hnd];
      end
      default: ;
    endcase
    r.entries_used = live_slots[HANDLE_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t pool_row(logic [POOL_CFG_W-1:0] v);
    plan_row_t row;
    row = '{kind: ROW_CFG, pool: v, act: '0, hnd: '0, sz: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t req_row(logic [ACTION_W-1:0] a, logic [HANDLE_W-1:0] h,
                                        logic [SIZE_W-1:0] s);
    plan_row_t row;
    row = '{kind: ROW_OP, pool: '0, act: a, hnd: h, sz: s, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t checked_row(logic [ACTION_W-1:0] a, logic [HANDLE_W-1:0] h,
                                            logic [SIZE_W-1:0] s, status_e st,
                                            int unsigned ho, int unsigned so,
                                            int unsigned cap, int unsigned used);
    plan_row_t row;
    row = req_row(a, h, s);
    row.typed = 1'b1;
    row.want.status       = st;
    row.want.handle_out   = ho[HANDLE_W-1:0];
    row.want.start_offset = so[SIZE_W-1:0];
    row.want.capacity     = cap[SIZE_W-1:0];
    row.want.entries_used = used[HANDLE_W-1:0];
    return row;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned sender_gap();
    int unsigned roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Present one item, wait for it to be taken, and record its result
  task automatic issue_request(logic [ACTION_W-1:0] act, logic [HANDLE_W-1:0] hnd,
                               logic [SIZE_W-1:0] sz, bit typed, alloc_result_t want);
    alloc_result_t predicted;
    start    <= 1'b1;
    action_i <= act;
    handle_i <= hnd;
    size_i   <= sz;
    do @(posedge clk_i); while (busy !== 1'b0);
    predicted = apply_request(act, hnd, sz);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop start for a random number of cycles after an item
  task automatic hold_off();
    int unsigned g;
    g = sender_gap();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Wait until every result is in and the block is idle
  task automatic settle_idle();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    do begin
      @(posedge clk_i);
      guard++;
    end while ((pending_results.size() != 0 || busy !== 1'b0) && guard < 5000);
    if (guard >= 5000) begin
      $error("timeout: %0d results still outstanding", pending_results.size());
      mismatches++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [POOL_CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    pool_bytes = v;
    cfg_valid_i <= 1'b0;
  endtask

  // Pick a mostly well-formed item from the tracked state
  task automatic pick_request(output logic [ACTION_W-1:0] act,
                              output logic [HANDLE_W-1:0] hnd,
                              output logic [SIZE_W-1:0] sz);
    int unsigned roll, alloc_share, span;
    roll        = $urandom_range(0, 99);
    alloc_share = (live_slots > 24) ? 25 : 45;
    span        = int'(pool_limit() / 12);
    hnd         = HANDLE_W'($urandom);
    sz          = SIZE_W'($urandom);
    if (roll < alloc_share) begin
      act  = ACT_ALLOC;
      roll = $urandom_range(0, 9);
      if (roll < 7) sz = SIZE_W'($urandom_range(0, span));
      else if (roll == 7) sz = '0;
    end else begin
      if (roll < 80) act = ACT_FREE;
      else if (roll < 95) act = ACT_QUERY;
      else act = ACT_UNUSED;
      // aim mostly at live handles, favoring the top of the stack
      if (live_slots > 0 && $urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 1) == 0) hnd = HANDLE_W'(live_slots - 1);
        else hnd = HANDLE_W'($urandom_range(0, live_slots - 1));
      end
    end
  endtask

  function automatic void check_field(string name, int unsigned want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result with the oldest outstanding one
  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: status %0d", status_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("handle_out", want.handle_out, handle_out_o);
        check_field("start_offset", want.start_offset, start_offset_o);
        check_field("capacity", want.capacity, capacity_o);
        check_field("entries_used", want.entries_used, entries_used_o);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** stack_handle_allocator: FAILED **");
    $finish;
  end

  initial begin
    logic [ACTION_W-1:0]   a;
    logic [HANDLE_W-1:0]   h;
    logic [SIZE_W-1:0]     s;
    logic [POOL_CFG_W-1:0] pool;
    int unsigned           top;

    directed_plan = '{
      pool_row('0),
      checked_row(ACT_ALLOC, 0, 0, STAT_POOL, 0, 0, 0, 0),
      checked_row(ACT_FREE, 0, 0, STAT_NOHANDLE, 0, 0, 0, 0),
      checked_row(ACT_QUERY, 1023, 0, STAT_NOHANDLE, 0, 0, 0, 0),
      checked_row(ACT_UNUSED, 1023, 20'hFFFFF, STAT_OK, 0, 0, 0, 0),
      pool_row(POOL_REG_MAX),
      checked_row(ACT_ALLOC, 0, 20'hFFFFF, STAT_OK, 0, 0, 0, 1),
      checked_row(ACT_ALLOC, 0, 1, STAT_POOL, 0, 0, 0, 1),
      checked_row(ACT_ALLOC, 0, 0, STAT_OK, 1, 20'hFFFFF, 0, 2),
      checked_row(ACT_QUERY, 0, 0, STAT_OK, 0, 0, 20'hFFFFF, 2),
      req_row(ACT_QUERY, 1, 0),
      checked_row(ACT_FREE, 0, 0, STAT_OK, 0, 0, 0, 2),
      checked_row(ACT_FREE, 0, 0, STAT_FREED, 0, 0, 0, 2),
      checked_row(ACT_QUERY, 0, 0, STAT_FREED, 0, 0, 0, 2),
      checked_row(ACT_FREE, 2, 0, STAT_NOHANDLE, 0, 0, 0, 2),
      checked_row(ACT_FREE, 1, 0, STAT_OK, 0, 0, 0, 0),
      req_row(ACT_ALLOC, 0, 20'hFFFFE),
      req_row(ACT_ALLOC, 0, 0),
      req_row(ACT_ALLOC, 1023, 1),
      req_row(ACT_FREE, 1, 0),
      req_row(ACT_FREE, 2, 0),
      req_row(ACT_QUERY, 0, 0),
      pool_row(16),
      checked_row(ACT_ALLOC, 0, 0, STAT_POOL, 0, 0, 0, 1),
      checked_row(ACT_FREE, 0, 0, STAT_OK, 0, 0, 0, 0),
      checked_row(ACT_ALLOC, 0, 15, STAT_OK, 0, 0, 0, 1),
      checked_row(ACT_ALLOC, 0, 1, STAT_POOL, 0, 0, 0, 1),
      req_row(ACT_QUERY, 0, 0)
    };

    // Hold reset, then release it at a clock edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed plan
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        settle_idle();
        write_pool(directed_plan[i].pool);
      end else begin
        issue_request(directed_plan[i].act, directed_plan[i].hnd, directed_plan[i].sz,
                      directed_plan[i].typed, directed_plan[i].want);
        hold_off();
      end
    end

    // Random traffic under several pool sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       pool = '0;
        1:       pool = POOL_CFG_W'($urandom_range(1, 64));
        2:       pool = POOL_REG_MAX;
        3:       pool = POOL_CFG_W'(POOL_SPAN);
        4:       pool = POOL_CFG_W'($urandom_range(1000, 200000));
        default: pool = POOL_CFG_W'($urandom);
      endcase
      gaps_on = (ph % 3 != 1);
      settle_idle();
      write_pool(pool);
      repeat (ph == 0 ? 20 : 50) begin
        pick_request(a, h, s);
        issue_request(a, h, s, 1'b0, '0);
        hold_off();
      end
    end

    // Fill the table with small allocations and a few queries
    gaps_on = 1'b1;
    settle_idle();
    write_pool(POOL_REG_MAX);
    while (live_slots < SLOTS - 1) begin
      if (live_slots > 0 && $urandom_range(0, 7) == 0) begin
        issue_request(ACT_QUERY, HANDLE_W'($urandom_range(0, live_slots - 1)), '0, 1'b0, '0);
      end else begin
        s = (pool_top + 3 < POOL_SPAN) ? SIZE_W'($urandom_range(0, 3)) : '0;
        issue_request(ACT_ALLOC, HANDLE_W'($urandom), s, 1'b0, '0);
      end
      hold_off();
    end

    // Hit the full table, with and without the pool also exhausted
    repeat (3) begin
      issue_request(ACT_ALLOC, HANDLE_W'($urandom), '0, 1'b0, '0);
      hold_off();
      issue_request(ACT_ALLOC, HANDLE_W'($urandom), 20'hFFFFF, 1'b0, '0);
      hold_off();
    end

    // Release a run under the top, then the top to pop the whole run
    top = live_slots - 1;
    for (int unsigned k = top - 20; k < top; k++) begin
      issue_request(ACT_FREE, HANDLE_W'(k), SIZE_W'($urandom), 1'b0, '0);
      hold_off();
    end
    issue_request(ACT_FREE, HANDLE_W'(top), '0, 1'b0, '0);
    hold_off();

    repeat (40) begin
      pick_request(a, h, s);
      issue_request(a, h, s, 1'b0, '0);
      hold_off();
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("** stack_handle_allocator: PASSED **");
    end else begin
      $display("** stack_handle_allocator: FAILED **");
    end
    $finish;
  end

endmodule
